[src/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants for the ternary carrier codec
// Operation codes, powers of three, reciprocal constants for the carrier
// division, and floating point field constants.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Operation select
  typedef enum logic [1:0] {
    FUNC_UNPACK = 2'd0,
    FUNC_PACK   = 2'd1,
    FUNC_H2S    = 2'd2,
    FUNC_S2H    = 2'd3
  } func_e;

  // Trit codes (two's complement)
  localparam logic [1:0] TRIT_NEG  = 2'b11;
  localparam logic [1:0] TRIT_ZERO = 2'b00;
  localparam logic [1:0] TRIT_POS  = 2'b01;

  localparam int unsigned NUM_TRITS = 5;

  // Powers of three for digit extraction
  typedef logic [7:0] pow3_t [NUM_TRITS];
  localparam pow3_t POW3 = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81};

  // Carrier places: 3^5 for wide, 3^4 for narrow
  localparam logic [15:0] PLACE_WIDE   = 16'd243;
  localparam logic [15:0] PLACE_NARROW = 16'd81;

  // floor(2^24 / place), estimates a quotient that is low by at most one
  localparam int unsigned RECIP_SHIFT  = 24;
  localparam logic [17:0] RECIP_WIDE   = 18'd69042;
  localparam logic [17:0] RECIP_NARROW = 18'd207126;

  // Floating point constants
  localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;   // 127 - 15
  localparam logic [7:0]  EXP_HALF_OVF  = 8'd143;   // 112 + 31
  localparam logic [7:0]  EXP_SINGLE_INF = 8'hFF;
  localparam logic [4:0]  EXP_HALF_INF  = 5'h1F;
  localparam logic [15:0] HALF_INF      = 16'h7C00;

endpackage

[src/ternary_carrier_codec_unit.sv]
// ----------------------------------------------------------------------------
// ternary_carrier_codec_unit: base-3 carrier codec and scale conversion
// Unpacks a carrier byte into trits, packs trits into a carrier byte, and
// converts scales between fp16 and float32, in a three stage pipeline.
// ----------------------------------------------------------------------------
// A request passes through the stage 1, stage 2 and output registers, in
// that order, before its result is offered on the outputs.
// Throughput: one request per cycle; the three stages advance together
// whenever the output register is empty or being drained.
// Reset: rst_ni clears the stage valid bits only; payload is not reset.
// Carrier division uses a reciprocal multiply in stage 2 and a single
// compare-and-correct in stage 3.

module ternary_carrier_codec_unit (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [7:0]         carrier_byte_i,
  input  logic [2:0]         digit_count_i,
  input  logic signed [1:0]  trit_0_i,
  input  logic signed [1:0]  trit_1_i,
  input  logic signed [1:0]  trit_2_i,
  input  logic signed [1:0]  trit_3_i,
  input  logic signed [1:0]  trit_4_i,
  input  logic [31:0]        number_word_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic signed [1:0]  out_trit_0_o,
  output logic signed [1:0]  out_trit_1_o,
  output logic signed [1:0]  out_trit_2_o,
  output logic signed [1:0]  out_trit_3_o,
  output logic signed [1:0]  out_trit_4_o,
  output logic [31:0]        out_word_o
);

  localparam int unsigned NT = tcc_pkg::NUM_TRITS;

  // Map a two-bit trit to a digit 0..2; the pattern 10 saturates to -1
  function automatic logic [1:0] trit_digit(input logic [1:0] raw);
    logic [1:0] d;
    case (raw)
      2'b01:   d = 2'd2;
      2'b00:   d = 2'd1;
      default: d = 2'd0;
    endcase
    return d;
  endfunction

  // Count leading zeros of a 10-bit mantissa
  function automatic logic [3:0] lzc10(input logic [9:0] man);
    logic [3:0] z;
    z = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) z = 4'(9 - i);
    end
    return z;
  endfunction

  // Pipeline enable: all stages move when the output slot frees up
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Stage 1: digit residues, pack numerator, mantissa leading zeros
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  tcc_pkg::func_e      s1_func_q;
  logic                s1_narrow_q;
  logic [7:0]          s1_res_q [NT];
  logic [15:0]         s1_num_q;
  logic [31:0]         s1_word_q;
  logic [3:0]          s1_lzc_q;

  logic                s1_narrow_d;
  logic [7:0]          s1_res_d [NT];
  logic [15:0]         s1_num_d;
  logic [1:0]          dig [NT];
  logic [7:0]          val;
  logic [15:0]         place;

  always_comb begin
    s1_narrow_d = (digit_count_i == 3'd4);
    for (int m = 0; m < NT; m++) begin
      s1_res_d[m] = 8'(16'(carrier_byte_i) * 16'(tcc_pkg::POW3[m]));
    end
    dig[0] = trit_digit(trit_0_i);
    dig[1] = trit_digit(trit_1_i);
    dig[2] = trit_digit(trit_2_i);
    dig[3] = trit_digit(trit_3_i);
    dig[4] = trit_digit(trit_4_i);
    if (s1_narrow_d) begin
      val   = 8'(8'(dig[0]) * 8'd27 + 8'(dig[1]) * 8'd9 + 8'(dig[2]) * 8'd3
                 + 8'(dig[3]));
      place = tcc_pkg::PLACE_NARROW;
    end else begin
      val   = 8'(8'(dig[0]) * 8'd81 + 8'(dig[1]) * 8'd27 + 8'(dig[2]) * 8'd9
                 + 8'(dig[3]) * 8'd3 + 8'(dig[4]));
      place = tcc_pkg::PLACE_WIDE;
    end
    // v * 256 + (place - 1), rounds the quotient up
    s1_num_d = {val, 8'h00} + (place - 16'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_func_q   <= tcc_pkg::func_e'(func_i);
      s1_narrow_q <= s1_narrow_d;
      s1_res_q    <= s1_res_d;
      s1_num_q    <= s1_num_d;
      s1_word_q   <= number_word_i;
      s1_lzc_q    <= lzc10(number_word_i[9:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: trit decode, quotient estimate, float conversion
  // --------------------------------------------------------------------------
  logic                s2_valid_q;
  tcc_pkg::func_e      s2_func_q;
  logic                s2_narrow_q;
  logic [1:0]          s2_trit_q [NT];
  logic [15:0]         s2_num_q;
  logic [9:0]          s2_qest_q;
  logic [31:0]         s2_word_q;

  logic [1:0]          s2_trit_d [NT];
  logic [9:0]          s2_qest_d;
  logic [31:0]         s2_word_d;
  logic [9:0]          tri3;
  logic [33:0]         recip_prod;
  logic                h_sign;
  logic [4:0]          h_ex;
  logic [9:0]          h_man;
  logic [3:0]          shamt;
  logic [19:0]         man_sh;
  logic [7:0]          f_ex;

  always_comb begin
    // Digit m is (residue * 3) >> 8, then minus one
    for (int m = 0; m < NT; m++) begin
      tri3 = {2'b00, s1_res_q[m]} + {1'b0, s1_res_q[m], 1'b0};
      case (tri3[9:8])
        2'd0:    s2_trit_d[m] = tcc_pkg::TRIT_NEG;
        2'd2:    s2_trit_d[m] = tcc_pkg::TRIT_POS;
        default: s2_trit_d[m] = tcc_pkg::TRIT_ZERO;
      endcase
      if (s1_func_q != tcc_pkg::FUNC_UNPACK) s2_trit_d[m] = tcc_pkg::TRIT_ZERO;
    end
    if (s1_narrow_q) s2_trit_d[NT-1] = tcc_pkg::TRIT_ZERO;

    // Reciprocal multiply, low by at most one
    recip_prod = 34'(s1_num_q) * 34'(s1_narrow_q ? tcc_pkg::RECIP_NARROW
                                                 : tcc_pkg::RECIP_WIDE);
    s2_qest_d  = recip_prod[tcc_pkg::RECIP_SHIFT +: 10];

    // Float conversion
    h_sign = s1_word_q[15];
    h_ex   = s1_word_q[14:10];
    h_man  = s1_word_q[9:0];
    shamt  = s1_lzc_q + 4'd1;
    man_sh = {10'b0, h_man} << shamt;
    f_ex   = s1_word_q[30:23];
    s2_word_d = '0;
    case (s1_func_q)
      tcc_pkg::FUNC_H2S: begin
        if (h_ex == 5'd0) begin
          if (h_man == 10'd0) begin
            s2_word_d = {h_sign, 31'b0};
          end else begin
            s2_word_d = {h_sign, tcc_pkg::EXP_BIAS_DIFF - 8'(s1_lzc_q),
                         man_sh[9:0], 13'b0};
          end
        end else if (h_ex == tcc_pkg::EXP_HALF_INF) begin
          s2_word_d = {h_sign, tcc_pkg::EXP_SINGLE_INF, h_man, 13'b0};
        end else begin
          s2_word_d = {h_sign, 8'(h_ex) + tcc_pkg::EXP_BIAS_DIFF, h_man, 13'b0};
        end
      end
      tcc_pkg::FUNC_S2H: begin
        if (f_ex <= tcc_pkg::EXP_BIAS_DIFF) begin
          s2_word_d = {16'b0, s1_word_q[31], 15'b0};
        end else if (f_ex >= tcc_pkg::EXP_HALF_OVF) begin
          s2_word_d = {16'b0, {s1_word_q[31], 15'b0} | tcc_pkg::HALF_INF};
        end else begin
          s2_word_d = {16'b0, s1_word_q[31], 5'(f_ex - tcc_pkg::EXP_BIAS_DIFF),
                       s1_word_q[22:13]};
        end
      end
      default: s2_word_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_func_q   <= s1_func_q;
      s2_narrow_q <= s1_narrow_q;
      s2_trit_q   <= s2_trit_d;
      s2_num_q    <= s1_num_q;
      s2_qest_q   <= s2_qest_d;
      s2_word_q   <= s2_word_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: quotient correction and output register
  // --------------------------------------------------------------------------
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic [1:0]          out_trit_q [NT];
  logic [31:0]         out_word_q;

  logic [7:0]          out_byte_d;
  logic [15:0]         s3_place;
  logic [15:0]         s3_rem;
  logic [9:0]          s3_quot;

  always_comb begin
    s3_place = s2_narrow_q ? tcc_pkg::PLACE_NARROW : tcc_pkg::PLACE_WIDE;
    s3_rem   = s2_num_q - 16'(16'(s2_qest_q) * s3_place);
    s3_quot  = (s3_rem >= s3_place) ? s2_qest_q + 10'd1 : s2_qest_q;
    out_byte_d = (s2_func_q == tcc_pkg::FUNC_PACK) ? s3_quot[7:0] : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_byte_q <= out_byte_d;
      out_trit_q <= s2_trit_q;
      out_word_q <= s2_word_q;
    end
  end

  // Drive outputs
  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_trit_0_o = out_trit_q[0];
  assign out_trit_1_o = out_trit_q[1];
  assign out_trit_2_o = out_trit_q[2];
  assign out_trit_3_o = out_trit_q[3];
  assign out_trit_4_o = out_trit_q[4];
  assign out_word_o   = out_word_q;

endmodule
